// ===== hdl/amrf_pkg.sv =====
// Shared types, sizes and codes of the associative-memory road finder.
package amrf_pkg;

    localparam int NUM_PATTERNS    = 64;
    localparam int NUM_LAYERS      = 8;
    localparam int NUM_SUPERSTRIPS = 1024;

    localparam int PAT_W    = 6;    // pattern number field
    localparam int LAY_W    = 3;    // layer field
    localparam int SS_W     = 11;   // superstrip field as it arrives
    localparam int SSI_W    = 10;   // stored superstrip
    localparam int CNT_W    = 4;    // matched-layer count
    localparam int TOT_W    = 7;    // road and kept totals, 0..64
    localparam int CFG_W    = 7;    // configuration write data
    localparam int HP_BIT_W = 5;    // bit select inside one hit-map row
    localparam int HP_ROW_W = LAY_W + SSI_W - HP_BIT_W;
    localparam int HP_WIDTH = 32;
    localparam int HP_ROWS  = 256;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_HIT   = 2'd1,
        ACT_END   = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_LOAD_OK  = 2'd0,
        ST_LOAD_REJ = 2'd1,
        ST_ROAD     = 2'd2,
        ST_NO_ROADS = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_MAX_MISS = 2'd0,
        CFG_GHOST    = 2'd1,
        CFG_PIU      = 2'd2,
        CFG_UNUSED   = 2'd3
    } cfg_index_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_LOAD, S_HIT_RD, S_HIT_WR, S_SCAN, S_CLEAR,
        S_RO_RL, S_RO_MB, S_RO_CHK, S_RO_CROW, S_RO_HRD, S_RO_HCAP,
        S_RO_KL, S_RO_KB, S_RO_KC, S_EM_RD, S_EM_OUT, S_EM_NONE
    } state_t;

    typedef logic [NUM_LAYERS-1:0][SSI_W-1:0] ss_row_t;

    typedef struct packed {
        logic [CNT_W-1:0] max_miss;
        logic             ghost;
        logic [CFG_W-1:0] piu;
    } cfg_t;

    typedef struct packed {
        logic    cap;
        logic    prep;
        logic    bank_wr;
        logic    hp_rd_hit;
        logic    hp_wr_hit;
        logic    scan_step;
        logic    ev_clear;
        logic    rl_rd;
        logic    mb_rd_cand;
        logic    cand_rd;
        logic    cand_cap;
        logic    hl_rd;
        logic    hl_cap;
        logic    kl_rd_j;
        logic    kb_rd;
        logic    j_next;
        logic    append;
        logic    adv_i;
        logic    kl_rd_k;
        logic    k_next;
        logic    emit;
        logic    emit_last;
        status_t emit_status;
    } cmd_t;

    typedef struct packed {
        action_t act;
        logic    load_bad;
        logic    scan_done;
        logic    rt_zero;
        logic    cnt_match;
        logic    nk_zero;
        logic    i_last;
        logic    c_last;
        logic    l_last;
        logic    j_last;
        logic    k_last;
        logic    ghost_hit;
        logic    ghost_on;
    } stat_t;

endpackage

// ===== hdl/amrf_dpath.sv =====
// Datapath of the road finder: pattern bank, hit map, match bits, road and kept lists.
module amrf_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  amrf_pkg::action_t            in_action,
    input  logic [amrf_pkg::PAT_W-1:0]   in_pat,
    input  logic [amrf_pkg::LAY_W-1:0]   in_layer,
    input  logic [amrf_pkg::SS_W-1:0]    in_ss,
    input  amrf_pkg::cfg_t               cfg,
    input  amrf_pkg::cmd_t               cmd,
    output amrf_pkg::stat_t              stat,
    output logic [amrf_pkg::PAT_W-1:0]   out_pat,
    output logic [amrf_pkg::CNT_W-1:0]   out_cnt
);

    function automatic logic [amrf_pkg::CNT_W-1:0] popcnt(
        input logic [amrf_pkg::NUM_LAYERS-1:0] v);
        logic [amrf_pkg::CNT_W-1:0] s;
        s = '0;
        for (int b = 0; b < amrf_pkg::NUM_LAYERS; b++)
            s = s + amrf_pkg::CNT_W'(v[b]);
        return s;
    endfunction

    // Memories.
    amrf_pkg::ss_row_t                       bank_mem [amrf_pkg::NUM_PATTERNS];
    logic [amrf_pkg::NUM_LAYERS-1:0]         mb_mem   [amrf_pkg::NUM_PATTERNS];
    logic [amrf_pkg::HP_WIDTH-1:0]           hp_mem   [amrf_pkg::HP_ROWS];
    logic [amrf_pkg::PAT_W-1:0]              rl_mem   [amrf_pkg::NUM_PATTERNS];
    logic [amrf_pkg::CNT_W+amrf_pkg::PAT_W-1:0] kl_mem [amrf_pkg::NUM_PATTERNS];

    logic [amrf_pkg::NUM_PATTERNS-1:0]       mb_valid_reg;
    logic [amrf_pkg::HP_ROWS-1:0]            hp_valid_reg;

    // Captured item.
    amrf_pkg::action_t                       act_reg;
    logic [amrf_pkg::PAT_W-1:0]              pat_reg;
    logic [amrf_pkg::LAY_W-1:0]              lay_reg;
    logic [amrf_pkg::SS_W-1:0]               ss_reg;

    // Registered read data.
    amrf_pkg::ss_row_t                       bank_rd_reg;
    logic [amrf_pkg::NUM_LAYERS-1:0]         mb_rd_reg;
    logic                                    mb_rv_reg;
    logic [amrf_pkg::HP_WIDTH-1:0]           hp_rd_reg;
    logic                                    hp_rv_reg;
    logic [amrf_pkg::PAT_W-1:0]              rl_rd_reg;
    logic [amrf_pkg::CNT_W+amrf_pkg::PAT_W-1:0] kl_rd_reg;

    // Sequencing counters and candidate state.
    logic [amrf_pkg::TOT_W-1:0]              p_reg;
    logic                                    pv_reg;
    logic [amrf_pkg::PAT_W-1:0]              p1_reg;
    logic [amrf_pkg::TOT_W-1:0]              rt_reg;
    logic [amrf_pkg::CNT_W-1:0]              c_reg;
    logic [amrf_pkg::PAT_W-1:0]              i_reg;
    logic [amrf_pkg::TOT_W-1:0]              nk_reg;
    logic [amrf_pkg::LAY_W-1:0]              l_reg;
    logic [amrf_pkg::PAT_W-1:0]              j_reg;
    logic [amrf_pkg::PAT_W-1:0]              k_reg;
    logic [amrf_pkg::PAT_W-1:0]              cand_reg;
    amrf_pkg::ss_row_t                       crow_reg;
    logic [amrf_pkg::NUM_LAYERS-1:0]         care_reg;

    logic [amrf_pkg::SSI_W-1:0]              ssc;
    logic                                    load_bad;
    logic [amrf_pkg::TOT_W-1:0]              limit;
    logic                                    p_in;
    logic                                    thr_ok;
    logic [amrf_pkg::CNT_W-1:0]              thr_val;
    logic [amrf_pkg::NUM_LAYERS-1:0]         mbits;
    logic [amrf_pkg::NUM_LAYERS-1:0]         lay_bit;
    logic [amrf_pkg::NUM_LAYERS-1:0]         mbits_new;
    logic                                    hit_new;
    logic                                    road_new;
    logic [amrf_pkg::HP_ROW_W-1:0]           hit_row;
    logic [amrf_pkg::HP_ROW_W-1:0]           cand_row;
    logic [amrf_pkg::SSI_W-1:0]              cand_ss;
    logic                                    hl_bit;
    logic                                    ghost;
    logic                                    bank_re;
    logic [amrf_pkg::PAT_W-1:0]              bank_ra;
    logic [amrf_pkg::PAT_W-1:0]              mb_ra;
    logic                                    i_last;

    assign ssc = (ss_reg >= amrf_pkg::SS_W'(amrf_pkg::NUM_SUPERSTRIPS))
               ? amrf_pkg::SSI_W'(amrf_pkg::NUM_SUPERSTRIPS - 1)
               : ss_reg[amrf_pkg::SSI_W-1:0];
    assign load_bad = ({1'b0, pat_reg} >= amrf_pkg::TOT_W'(amrf_pkg::NUM_PATTERNS))
                   || ({1'b0, lay_reg} >= (amrf_pkg::LAY_W+1)'(amrf_pkg::NUM_LAYERS))
                   || (ss_reg >= amrf_pkg::SS_W'(amrf_pkg::NUM_SUPERSTRIPS));
    assign limit = (cfg.piu > amrf_pkg::TOT_W'(amrf_pkg::NUM_PATTERNS))
                 ? amrf_pkg::TOT_W'(amrf_pkg::NUM_PATTERNS) : cfg.piu;
    assign p_in    = p_reg < limit;
    assign thr_ok  = cfg.max_miss < amrf_pkg::CNT_W'(amrf_pkg::NUM_LAYERS);
    assign thr_val = amrf_pkg::CNT_W'(amrf_pkg::NUM_LAYERS) - cfg.max_miss;

    // Scan stage: compare the fetched bank row with the hit.
    assign mbits     = mb_rv_reg ? mb_rd_reg : '0;
    assign lay_bit   = amrf_pkg::NUM_LAYERS'(1) << lay_reg;
    assign mbits_new = mbits | lay_bit;
    assign hit_new   = pv_reg && (bank_rd_reg[lay_reg] == ssc) && !mbits[lay_reg];
    assign road_new  = hit_new && thr_ok && (popcnt(mbits_new) == thr_val)
                    && (rt_reg < amrf_pkg::TOT_W'(amrf_pkg::NUM_PATTERNS));

    assign hit_row  = {lay_reg, ssc[amrf_pkg::SSI_W-1:amrf_pkg::HP_BIT_W]};
    assign cand_ss  = crow_reg[l_reg];
    assign cand_row = {l_reg, cand_ss[amrf_pkg::SSI_W-1:amrf_pkg::HP_BIT_W]};
    assign hl_bit   = hp_rv_reg && hp_rd_reg[cand_ss[amrf_pkg::HP_BIT_W-1:0]];

    always_comb
    begin
        ghost = 1'b1;
        for (int l = 0; l < amrf_pkg::NUM_LAYERS; l++)
            if (care_reg[l] && (bank_rd_reg[l] != crow_reg[l]))
                ghost = 1'b0;
    end

    assign bank_re = (cmd.scan_step && p_in) || cmd.cand_rd || cmd.kb_rd;
    always_comb
    begin
        priority if (cmd.cand_rd)
            bank_ra = cand_reg;
        else if (cmd.kb_rd)
            bank_ra = kl_rd_reg[amrf_pkg::PAT_W-1:0];
        else
            bank_ra = p_reg[amrf_pkg::PAT_W-1:0];
    end
    assign mb_ra = cmd.mb_rd_cand ? rl_rd_reg : p_reg[amrf_pkg::PAT_W-1:0];

    assign i_last = ({1'b0, i_reg} + 1'b1) == rt_reg;

    // Memories and payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            act_reg <= in_action;
            pat_reg <= in_pat;
            lay_reg <= in_layer;
            ss_reg  <= in_ss;
        end
        if (cmd.bank_wr && !load_bad)
            bank_mem[pat_reg][lay_reg] <= ss_reg[amrf_pkg::SSI_W-1:0];
        if (bank_re)
            bank_rd_reg <= bank_mem[bank_ra];
        if (cmd.scan_step || cmd.mb_rd_cand)
        begin
            mb_rd_reg <= mb_mem[mb_ra];
            mb_rv_reg <= mb_valid_reg[mb_ra];
        end
        if (cmd.scan_step)
            p1_reg <= p_reg[amrf_pkg::PAT_W-1:0];
        if (cmd.scan_step && hit_new)
            mb_mem[p1_reg] <= mbits_new;
        if (cmd.scan_step && road_new)
            rl_mem[rt_reg[amrf_pkg::PAT_W-1:0]] <= p1_reg;
        if (cmd.hp_rd_hit || cmd.hl_rd)
        begin
            hp_rd_reg <= hp_mem[cmd.hl_rd ? cand_row : hit_row];
            hp_rv_reg <= hp_valid_reg[cmd.hl_rd ? cand_row : hit_row];
        end
        if (cmd.hp_wr_hit)
            hp_mem[hit_row] <= (hp_rv_reg ? hp_rd_reg : '0)
                             | (amrf_pkg::HP_WIDTH'(1) << ssc[amrf_pkg::HP_BIT_W-1:0]);
        if (cmd.rl_rd)
            rl_rd_reg <= rl_mem[i_reg];
        if (cmd.mb_rd_cand)
            cand_reg <= rl_rd_reg;
        if (cmd.cand_cap)
            crow_reg <= bank_rd_reg;
        if (cmd.hl_cap)
            care_reg[l_reg] <= hl_bit;
        if (cmd.kl_rd_j || cmd.kl_rd_k)
            kl_rd_reg <= kl_mem[cmd.kl_rd_k ? k_reg : j_reg];
        if (cmd.append)
            kl_mem[nk_reg[amrf_pkg::PAT_W-1:0]] <= {c_reg, cand_reg};
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_reg        <= '0;
            pv_reg       <= 1'b0;
            rt_reg       <= '0;
            c_reg        <= '0;
            i_reg        <= '0;
            nk_reg       <= '0;
            l_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            mb_valid_reg <= '0;
            hp_valid_reg <= '0;
        end
        else
        begin
            if (cmd.prep)
            begin
                p_reg  <= '0;
                pv_reg <= 1'b0;
                c_reg  <= amrf_pkg::CNT_W'(amrf_pkg::NUM_LAYERS);
                i_reg  <= '0;
                nk_reg <= '0;
                k_reg  <= '0;
            end
            if (cmd.scan_step)
            begin
                pv_reg <= p_in;
                if (p_in)
                    p_reg <= p_reg + 1'b1;
                if (hit_new)
                    mb_valid_reg[p1_reg] <= 1'b1;
                if (road_new)
                    rt_reg <= rt_reg + 1'b1;
            end
            if (cmd.hp_wr_hit)
                hp_valid_reg[hit_row] <= 1'b1;
            if (cmd.adv_i)
            begin
                if (i_last)
                begin
                    i_reg <= '0;
                    c_reg <= c_reg - 1'b1;
                end
                else
                    i_reg <= i_reg + 1'b1;
            end
            if (cmd.cand_cap)
            begin
                l_reg <= '0;
                j_reg <= '0;
            end
            if (cmd.hl_cap)
                l_reg <= l_reg + 1'b1;
            if (cmd.j_next)
                j_reg <= j_reg + 1'b1;
            if (cmd.append)
                nk_reg <= nk_reg + 1'b1;
            if (cmd.k_next)
                k_reg <= k_reg + 1'b1;
            if (cmd.ev_clear)
            begin
                mb_valid_reg <= '0;
                hp_valid_reg <= '0;
                rt_reg       <= '0;
            end
        end
    end

    assign stat.act       = act_reg;
    assign stat.load_bad  = load_bad;
    assign stat.scan_done = !p_in && !pv_reg;
    assign stat.rt_zero   = rt_reg == '0;
    assign stat.cnt_match = popcnt(mbits) == c_reg;
    assign stat.nk_zero   = nk_reg == '0;
    assign stat.i_last    = i_last;
    assign stat.c_last    = c_reg == amrf_pkg::CNT_W'(1);
    assign stat.l_last    = l_reg == amrf_pkg::LAY_W'(amrf_pkg::NUM_LAYERS - 1);
    assign stat.j_last    = ({1'b0, j_reg} + 1'b1) == nk_reg;
    assign stat.k_last    = ({1'b0, k_reg} + 1'b1) == nk_reg;
    assign stat.ghost_hit = ghost;
    assign stat.ghost_on  = cfg.ghost;

    assign out_pat = kl_rd_reg[amrf_pkg::PAT_W-1:0];
    assign out_cnt = kl_rd_reg[amrf_pkg::CNT_W+amrf_pkg::PAT_W-1:amrf_pkg::PAT_W];

endmodule

// ===== hdl/amrf_ctrl.sv =====
// Controller state machine of the road finder.
module amrf_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            emit_ok,
    input  amrf_pkg::stat_t stat,
    output logic            in_ready,
    output amrf_pkg::cmd_t  cmd
);

    amrf_pkg::state_t state_reg;
    amrf_pkg::state_t state_next;
    amrf_pkg::state_t after_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= amrf_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // Where a readout goes once the current candidate is settled.
    assign after_adv = (stat.i_last && stat.c_last) ? amrf_pkg::S_EM_RD : amrf_pkg::S_RO_RL;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            amrf_pkg::S_IDLE:
                if (in_valid)
                    state_next = amrf_pkg::S_DISP;
            amrf_pkg::S_DISP:
                unique case (stat.act)
                    amrf_pkg::ACT_LOAD:  state_next = amrf_pkg::S_LOAD;
                    amrf_pkg::ACT_HIT:   state_next = amrf_pkg::S_HIT_RD;
                    amrf_pkg::ACT_END:   state_next = stat.rt_zero ? amrf_pkg::S_EM_RD
                                                                   : amrf_pkg::S_RO_RL;
                    amrf_pkg::ACT_CLEAR: state_next = amrf_pkg::S_CLEAR;
                endcase
            amrf_pkg::S_LOAD:
                if (emit_ok)
                    state_next = amrf_pkg::S_IDLE;
            amrf_pkg::S_HIT_RD:  state_next = amrf_pkg::S_HIT_WR;
            amrf_pkg::S_HIT_WR:  state_next = amrf_pkg::S_SCAN;
            amrf_pkg::S_SCAN:
                if (stat.scan_done)
                    state_next = amrf_pkg::S_IDLE;
            amrf_pkg::S_CLEAR:   state_next = amrf_pkg::S_IDLE;
            amrf_pkg::S_RO_RL:   state_next = amrf_pkg::S_RO_MB;
            amrf_pkg::S_RO_MB:   state_next = amrf_pkg::S_RO_CHK;
            amrf_pkg::S_RO_CHK:
                priority if (!stat.cnt_match || !stat.ghost_on || stat.nk_zero)
                    state_next = after_adv;
                else
                    state_next = amrf_pkg::S_RO_CROW;
            amrf_pkg::S_RO_CROW: state_next = amrf_pkg::S_RO_HRD;
            amrf_pkg::S_RO_HRD:  state_next = amrf_pkg::S_RO_HCAP;
            amrf_pkg::S_RO_HCAP: state_next = stat.l_last ? amrf_pkg::S_RO_KL
                                                          : amrf_pkg::S_RO_HRD;
            amrf_pkg::S_RO_KL:   state_next = amrf_pkg::S_RO_KB;
            amrf_pkg::S_RO_KB:   state_next = amrf_pkg::S_RO_KC;
            amrf_pkg::S_RO_KC:
                priority if (stat.ghost_hit || stat.j_last)
                    state_next = after_adv;
                else
                    state_next = amrf_pkg::S_RO_KL;
            amrf_pkg::S_EM_RD:   state_next = stat.nk_zero ? amrf_pkg::S_EM_NONE
                                                           : amrf_pkg::S_EM_OUT;
            amrf_pkg::S_EM_OUT:
                if (emit_ok)
                    state_next = stat.k_last ? amrf_pkg::S_IDLE : amrf_pkg::S_EM_RD;
            amrf_pkg::S_EM_NONE:
                if (emit_ok)
                    state_next = amrf_pkg::S_IDLE;
            default:             state_next = amrf_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.emit_status = amrf_pkg::ST_LOAD_OK;
        in_ready        = 1'b0;
        unique case (state_reg)
            amrf_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.cap  = in_valid;
            end
            amrf_pkg::S_DISP:    cmd.prep = 1'b1;
            amrf_pkg::S_LOAD:
                if (emit_ok)
                begin
                    cmd.bank_wr     = 1'b1;
                    cmd.emit        = 1'b1;
                    cmd.emit_last   = 1'b1;
                    cmd.emit_status = stat.load_bad ? amrf_pkg::ST_LOAD_REJ
                                                    : amrf_pkg::ST_LOAD_OK;
                end
            amrf_pkg::S_HIT_RD:  cmd.hp_rd_hit = 1'b1;
            amrf_pkg::S_HIT_WR:  cmd.hp_wr_hit = 1'b1;
            amrf_pkg::S_SCAN:    cmd.scan_step = !stat.scan_done;
            amrf_pkg::S_CLEAR:   cmd.ev_clear  = 1'b1;
            amrf_pkg::S_RO_RL:   cmd.rl_rd     = 1'b1;
            amrf_pkg::S_RO_MB:   cmd.mb_rd_cand = 1'b1;
            amrf_pkg::S_RO_CHK:
                priority if (!stat.cnt_match)
                    cmd.adv_i = 1'b1;
                else if (!stat.ghost_on || stat.nk_zero)
                begin
                    cmd.append = 1'b1;
                    cmd.adv_i  = 1'b1;
                end
                else
                    cmd.cand_rd = 1'b1;
            amrf_pkg::S_RO_CROW: cmd.cand_cap = 1'b1;
            amrf_pkg::S_RO_HRD:  cmd.hl_rd    = 1'b1;
            amrf_pkg::S_RO_HCAP: cmd.hl_cap   = 1'b1;
            amrf_pkg::S_RO_KL:   cmd.kl_rd_j  = 1'b1;
            amrf_pkg::S_RO_KB:   cmd.kb_rd    = 1'b1;
            amrf_pkg::S_RO_KC:
                priority if (stat.ghost_hit)
                    cmd.adv_i = 1'b1;
                else if (stat.j_last)
                begin
                    cmd.append = 1'b1;
                    cmd.adv_i  = 1'b1;
                end
                else
                    cmd.j_next = 1'b1;
            amrf_pkg::S_EM_RD:   cmd.kl_rd_k = !stat.nk_zero;
            amrf_pkg::S_EM_OUT:
                if (emit_ok)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = amrf_pkg::ST_ROAD;
                    cmd.emit_last   = stat.k_last;
                    cmd.k_next      = 1'b1;
                    cmd.ev_clear    = stat.k_last;
                end
            amrf_pkg::S_EM_NONE:
                if (emit_ok)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_status = amrf_pkg::ST_NO_ROADS;
                    cmd.emit_last   = 1'b1;
                    cmd.ev_clear    = 1'b1;
                end
            default:             cmd = '0;
        endcase
    end

endmodule

// ===== hdl/associative_memory_road_finder_top.sv =====
// Top level of the associative-memory road finder: configuration, control, datapath, output.
//
// The block holds a bank of 64 patterns with one superstrip per each of 8 layers and finds
// the roads of an event. Items arrive one at a time on the slave stream; tuser carries the
// action, tdata the load or hit fields. A load keeps the input busy until its answer is
// in the output register and returns one transaction saying whether it was accepted. A hit,
// with patterns_in_use counted as at most 64, is decoded and records itself in the hit map
// by a read and a write; then a single comparator walks that many patterns of the bank one
// pattern per cycle and updates each pattern's layer match bits, and the input stays busy
// until the walk has drained. A clear-only item clears the event state. An end-of-event item
// runs the readout after decoding: the road list is swept once per matched-layer count from
// 8 down to 1, which yields the stable order by count; with ghost removal on, each candidate
// that could be kept then has its hit mask fetched layer by layer and is compared with the
// roads already kept, one by one. The kept roads are then sent one transaction each, the
// last marked by tlast, or a single no-roads transaction, and the event state is cleared at
// once through valid bits. The output register holds one result; while it waits for the
// sink, a load or the next road of a readout waits behind it and the input stays busy until
// then.
module associative_memory_road_finder_top (
    input  logic        clk,
    input  logic        rst_n,
    // Input stream. tdata: pattern_number[5:0], layer[8:6], superstrip[19:9].
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    // tuser: action[1:0].
    input  logic [1:0]  s_axis_tuser,
    // Result stream. tdata: road_pattern[5:0], matched_layers[9:6].
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    // tuser: status[1:0]. tlast: is_last.
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);

    logic [amrf_pkg::CNT_W-1:0] max_miss_reg;
    logic                       ghost_reg;
    logic [amrf_pkg::CFG_W-1:0] piu_reg;
    amrf_pkg::cfg_t             cfg;
    amrf_pkg::cmd_t             cmd;
    amrf_pkg::stat_t            stat;
    logic [amrf_pkg::PAT_W-1:0] road_pat;
    logic [amrf_pkg::CNT_W-1:0] road_cnt;
    logic                       emit_ok;
    logic                       out_valid_reg;
    logic [15:0]                out_data_reg;
    amrf_pkg::status_t          out_status_reg;
    logic                       out_last_reg;

    assign cfg_ready = 1'b1;

    // Configuration registers; a write to the spare index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_miss_reg <= '0;
            ghost_reg    <= 1'b1;
            piu_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (amrf_pkg::cfg_index_t'(cfg_index))
                amrf_pkg::CFG_MAX_MISS: max_miss_reg <= cfg_data[amrf_pkg::CNT_W-1:0];
                amrf_pkg::CFG_GHOST:    ghost_reg    <= cfg_data[0];
                amrf_pkg::CFG_PIU:      piu_reg      <= cfg_data;
                amrf_pkg::CFG_UNUSED:   ;
            endcase
        end
    end

    assign cfg.max_miss = max_miss_reg;
    assign cfg.ghost    = ghost_reg;
    assign cfg.piu      = piu_reg;

    assign emit_ok = !out_valid_reg || m_axis_tready;

    amrf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .emit_ok  (emit_ok),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    amrf_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_action (amrf_pkg::action_t'(s_axis_tuser)),
        .in_pat    (s_axis_tdata[5:0]),
        .in_layer  (s_axis_tdata[8:6]),
        .in_ss     (s_axis_tdata[19:9]),
        .cfg       (cfg),
        .cmd       (cmd),
        .stat      (stat),
        .out_pat   (road_pat),
        .out_cnt   (road_cnt)
    );

    // Output register: a finished result waits here until the sink takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_status_reg <= cmd.emit_status;
            out_last_reg   <= cmd.emit_last;
            if (cmd.emit_status == amrf_pkg::ST_ROAD)
                out_data_reg <= {6'd0, road_cnt, road_pat};
            else
                out_data_reg <= '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== hdl/amrf_checker.sv =====
// Port-level checker of the road finder and its bind to the top level.
module amrf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [23:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [6:0]  cfg_data
);

    // A stalled result transaction holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // Load answers and the no-roads answer stand alone.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != amrf_pkg::ST_ROAD) |-> m_axis_tlast)
        else $error("single result without tlast");

    // Only a road carries pattern and count.
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != amrf_pkg::ST_ROAD) |-> m_axis_tdata == 16'd0)
        else $error("non-road result carries data");

    // One item is worked on at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

endmodule

bind associative_memory_road_finder_top amrf_checker u_amrf_checker (.*);
